@@ sv/imfe_pkg.sv @@
`timescale 1ns / 1ps

package imfe_pkg;

    // sizes
    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = 10;
    localparam int LABEL_W   = 11;
    localparam int ARC_W     = 14;
    localparam int ARC_SLOTS = 8194;
    localparam int CAP_W     = 16;
    localparam int FLOW_W    = 32;
    localparam int CNT_W     = 11;
    localparam int OP_W      = 6;

    localparam logic [ARC_W:0]   ARC_LAST  = 15'd8193;
    localparam logic [LABEL_W-1:0] LABEL_INF = 11'd1024;
    localparam logic [LABEL_W-1:0] LABEL_TOP = 11'd1023;

    // command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_EXCL = 2'd1;
    localparam logic [1:0] CMD_RUN  = 2'd2;

    // sequencer steps, also the operation code sent to the datapath
    localparam logic [OP_W-1:0] ST_CLR0  = 6'd0;
    localparam logic [OP_W-1:0] ST_IDLE  = 6'd1;
    localparam logic [OP_W-1:0] ST_DISP  = 6'd2;
    localparam logic [OP_W-1:0] ST_LD1   = 6'd3;
    localparam logic [OP_W-1:0] ST_LD2   = 6'd4;
    localparam logic [OP_W-1:0] ST_LD3   = 6'd5;
    localparam logic [OP_W-1:0] ST_LD4   = 6'd6;
    localparam logic [OP_W-1:0] ST_EXCL  = 6'd7;
    localparam logic [OP_W-1:0] ST_RCLR  = 6'd8;
    localparam logic [OP_W-1:0] ST_BINIT = 6'd9;
    localparam logic [OP_W-1:0] ST_BPOP  = 6'd10;
    localparam logic [OP_W-1:0] ST_BU    = 6'd11;
    localparam logic [OP_W-1:0] ST_BARC  = 6'd12;
    localparam logic [OP_W-1:0] ST_BLOOP = 6'd13;
    localparam logic [OP_W-1:0] ST_BW    = 6'd14;
    localparam logic [OP_W-1:0] ST_BCHK  = 6'd15;
    localparam logic [OP_W-1:0] ST_H1    = 6'd16;
    localparam logic [OP_W-1:0] ST_H2    = 6'd17;
    localparam logic [OP_W-1:0] ST_H3    = 6'd18;
    localparam logic [OP_W-1:0] ST_MAIN  = 6'd19;
    localparam logic [OP_W-1:0] ST_P0    = 6'd20;
    localparam logic [OP_W-1:0] ST_P1    = 6'd21;
    localparam logic [OP_W-1:0] ST_P2    = 6'd22;
    localparam logic [OP_W-1:0] ST_P3    = 6'd23;
    localparam logic [OP_W-1:0] ST_P4    = 6'd24;
    localparam logic [OP_W-1:0] ST_P5    = 6'd25;
    localparam logic [OP_W-1:0] ST_P6    = 6'd26;
    localparam logic [OP_W-1:0] ST_P7    = 6'd27;
    localparam logic [OP_W-1:0] ST_P8    = 6'd28;
    localparam logic [OP_W-1:0] ST_A0    = 6'd29;
    localparam logic [OP_W-1:0] ST_A1    = 6'd30;
    localparam logic [OP_W-1:0] ST_A2    = 6'd31;
    localparam logic [OP_W-1:0] ST_A3    = 6'd32;
    localparam logic [OP_W-1:0] ST_A4    = 6'd33;
    localparam logic [OP_W-1:0] ST_R0    = 6'd34;
    localparam logic [OP_W-1:0] ST_R1    = 6'd35;
    localparam logic [OP_W-1:0] ST_R2    = 6'd36;
    localparam logic [OP_W-1:0] ST_R3    = 6'd37;
    localparam logic [OP_W-1:0] ST_R4    = 6'd38;
    localparam logic [OP_W-1:0] ST_R5    = 6'd39;
    localparam logic [OP_W-1:0] ST_R6    = 6'd40;
    localparam logic [OP_W-1:0] ST_R7    = 6'd41;
    localparam logic [OP_W-1:0] ST_R8    = 6'd42;
    localparam logic [OP_W-1:0] ST_R9    = 6'd43;
    localparam logic [OP_W-1:0] ST_R10   = 6'd44;
    localparam logic [OP_W-1:0] ST_DONE  = 6'd45;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       same_ab;
        logic       n_1023;
        logic       n_1024;
        logic       fifo_empty;
        logic       i_zero;
        logic       bfs_take;
        logic       src_done;
        logic       u_is_sink;
        logic       u_is_src;
        logic       x_is_src;
        logic       adm;
        logic       hist_one;
    } t_sts;

endpackage

@@ sv/imfe_ctrl.sv @@
`timescale 1ns / 1ps

module imfe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  imfe_pkg::t_sts   i_sts,
    output imfe_pkg::t_ctl   o_ctl
);

    logic [imfe_pkg::OP_W-1:0] r_state;
    logic [imfe_pkg::OP_W-1:0] n_state;

    // next step
    always_comb begin
        n_state = r_state;
        case (r_state)
            imfe_pkg::ST_CLR0:  if (i_sts.n_1023) n_state = imfe_pkg::ST_IDLE;
            imfe_pkg::ST_IDLE:  if (i_start) n_state = imfe_pkg::ST_DISP;
            imfe_pkg::ST_DISP: begin
                case (i_sts.cmd)
                    imfe_pkg::CMD_LOAD: n_state = i_sts.full ? imfe_pkg::ST_IDLE
                                                             : imfe_pkg::ST_LD1;
                    imfe_pkg::CMD_EXCL: n_state = imfe_pkg::ST_EXCL;
                    imfe_pkg::CMD_RUN:  n_state = i_sts.same_ab ? imfe_pkg::ST_DONE
                                                                : imfe_pkg::ST_RCLR;
                    default:            n_state = imfe_pkg::ST_IDLE;
                endcase
            end
            imfe_pkg::ST_LD1:   n_state = imfe_pkg::ST_LD2;
            imfe_pkg::ST_LD2:   n_state = imfe_pkg::ST_LD3;
            imfe_pkg::ST_LD3:   n_state = imfe_pkg::ST_LD4;
            imfe_pkg::ST_LD4:   n_state = imfe_pkg::ST_IDLE;
            imfe_pkg::ST_EXCL:  n_state = imfe_pkg::ST_IDLE;
            imfe_pkg::ST_RCLR:  if (i_sts.n_1024) n_state = imfe_pkg::ST_BINIT;
            imfe_pkg::ST_BINIT: n_state = imfe_pkg::ST_BPOP;
            imfe_pkg::ST_BPOP:  n_state = i_sts.fifo_empty ? imfe_pkg::ST_H1
                                                           : imfe_pkg::ST_BU;
            imfe_pkg::ST_BU:    n_state = imfe_pkg::ST_BARC;
            imfe_pkg::ST_BARC:  n_state = imfe_pkg::ST_BLOOP;
            imfe_pkg::ST_BLOOP: n_state = i_sts.i_zero ? imfe_pkg::ST_BPOP
                                                       : imfe_pkg::ST_BW;
            imfe_pkg::ST_BW:    n_state = imfe_pkg::ST_BCHK;
            imfe_pkg::ST_BCHK:  n_state = imfe_pkg::ST_BLOOP;
            imfe_pkg::ST_H1:    n_state = imfe_pkg::ST_H2;
            imfe_pkg::ST_H2:    n_state = imfe_pkg::ST_H3;
            imfe_pkg::ST_H3:    n_state = i_sts.n_1023 ? imfe_pkg::ST_MAIN
                                                       : imfe_pkg::ST_H1;
            imfe_pkg::ST_MAIN: begin
                if (i_sts.src_done)
                    n_state = imfe_pkg::ST_DONE;
                else if (i_sts.u_is_sink)
                    n_state = imfe_pkg::ST_P0;
                else
                    n_state = imfe_pkg::ST_A0;
            end
            // augment: bottleneck pass, then update pass
            imfe_pkg::ST_P0:    n_state = imfe_pkg::ST_P1;
            imfe_pkg::ST_P1:    n_state = i_sts.x_is_src ? imfe_pkg::ST_P4
                                                         : imfe_pkg::ST_P2;
            imfe_pkg::ST_P2:    n_state = imfe_pkg::ST_P3;
            imfe_pkg::ST_P3:    n_state = imfe_pkg::ST_P1;
            imfe_pkg::ST_P4:    n_state = imfe_pkg::ST_P5;
            imfe_pkg::ST_P5:    n_state = i_sts.x_is_src ? imfe_pkg::ST_MAIN
                                                         : imfe_pkg::ST_P6;
            imfe_pkg::ST_P6:    n_state = imfe_pkg::ST_P7;
            imfe_pkg::ST_P7:    n_state = imfe_pkg::ST_P8;
            imfe_pkg::ST_P8:    n_state = imfe_pkg::ST_P5;
            // advance on current arc
            imfe_pkg::ST_A0:    n_state = imfe_pkg::ST_A1;
            imfe_pkg::ST_A1:    n_state = imfe_pkg::ST_A2;
            imfe_pkg::ST_A2:    n_state = i_sts.i_zero ? imfe_pkg::ST_R0
                                                       : imfe_pkg::ST_A3;
            imfe_pkg::ST_A3:    n_state = imfe_pkg::ST_A4;
            imfe_pkg::ST_A4:    n_state = i_sts.adm ? imfe_pkg::ST_MAIN
                                                    : imfe_pkg::ST_A2;
            // retreat with relabel and gap check
            imfe_pkg::ST_R0:    n_state = imfe_pkg::ST_R1;
            imfe_pkg::ST_R1:    n_state = imfe_pkg::ST_R2;
            imfe_pkg::ST_R2:    n_state = i_sts.i_zero ? imfe_pkg::ST_R5
                                                       : imfe_pkg::ST_R3;
            imfe_pkg::ST_R3:    n_state = imfe_pkg::ST_R4;
            imfe_pkg::ST_R4:    n_state = imfe_pkg::ST_R2;
            imfe_pkg::ST_R5:    n_state = imfe_pkg::ST_R6;
            imfe_pkg::ST_R6:    n_state = i_sts.hist_one ? imfe_pkg::ST_DONE
                                                         : imfe_pkg::ST_R7;
            imfe_pkg::ST_R7:    n_state = imfe_pkg::ST_R8;
            imfe_pkg::ST_R8:    n_state = i_sts.u_is_src ? imfe_pkg::ST_MAIN
                                                         : imfe_pkg::ST_R9;
            imfe_pkg::ST_R9:    n_state = imfe_pkg::ST_R10;
            imfe_pkg::ST_R10:   n_state = imfe_pkg::ST_MAIN;
            imfe_pkg::ST_DONE:  n_state = imfe_pkg::ST_IDLE;
            default:            n_state = imfe_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imfe_pkg::ST_CLR0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl.op = r_state;

endmodule

@@ sv/imfe_datapath.sv @@
`timescale 1ns / 1ps

module imfe_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  imfe_pkg::t_ctl                i_ctl,
    input  logic [1:0]                    i_command,
    input  logic [imfe_pkg::NODE_W-1:0]   i_node_a,
    input  logic [imfe_pkg::NODE_W-1:0]   i_node_b,
    input  logic [imfe_pkg::CAP_W-1:0]    i_capacity,
    output imfe_pkg::t_sts                o_sts,
    output logic [imfe_pkg::FLOW_W-1:0]   o_max_flow,
    output logic [imfe_pkg::CNT_W-1:0]    o_path_node_count,
    output logic                          o_status
);

    localparam int NW = imfe_pkg::NODE_W;
    localparam int AW = imfe_pkg::ARC_W;
    localparam int LW = imfe_pkg::LABEL_W;
    localparam int CW = imfe_pkg::CAP_W;

    // memories
    logic [NW-1:0] mem_target [imfe_pkg::ARC_SLOTS];
    logic [CW-1:0] mem_resid  [imfe_pkg::ARC_SLOTS];
    logic [AW-1:0] mem_link   [imfe_pkg::ARC_SLOTS];
    logic [AW-1:0] mem_head   [imfe_pkg::MAX_NODES];
    logic [AW-1:0] mem_cur    [imfe_pkg::MAX_NODES];
    logic [AW-1:0] mem_par    [imfe_pkg::MAX_NODES];
    logic [LW-1:0] mem_dist   [imfe_pkg::MAX_NODES];
    logic [LW-1:0] mem_hist   [imfe_pkg::MAX_NODES + 1];
    logic          mem_seen   [imfe_pkg::MAX_NODES];
    logic [NW-1:0] mem_fifo   [imfe_pkg::MAX_NODES];
    logic          mem_excl   [imfe_pkg::MAX_NODES];
    logic          mem_onp    [imfe_pkg::MAX_NODES];

    // memory ports
    logic          tg_we, rs_we, lk_we, hd_we, cu_we, pa_we, di_we, hi_we;
    logic          se_we, ff_we, ex_we, op_we;
    logic [AW-1:0] tg_wa, rs_wa, lk_wa, tg_ra, rs_ra, lk_ra;
    logic [NW-1:0] hd_wa, cu_wa, pa_wa, di_wa, se_wa, ff_wa, ex_wa, op_wa;
    logic [NW-1:0] hd_ra, cu_ra, pa_ra, di_ra, se_ra, ff_ra, ex_ra, op_ra;
    logic [LW-1:0] hi_wa, hi_ra;
    logic [NW-1:0] tg_wd, ff_wd;
    logic [CW-1:0] rs_wd;
    logic [AW-1:0] lk_wd, hd_wd, cu_wd, pa_wd;
    logic [LW-1:0] di_wd, hi_wd;
    logic          se_wd, ex_wd, op_wd;
    logic [NW-1:0] tg_q, ff_q;
    logic [CW-1:0] rs_q;
    logic [AW-1:0] lk_q, hd_q, cu_q, pa_q;
    logic [LW-1:0] di_q, hi_q;
    logic          se_q, ex_q, op_q;

    // registers
    logic [1:0]        r_cmd, n_cmd;
    logic [NW-1:0]     r_a, n_a, r_b, n_b;
    logic [CW-1:0]     r_cap, n_cap;
    logic [AW-1:0]     r_fill, n_fill;
    logic              r_drop, n_drop;
    logic [LW-1:0]     r_n, n_n;
    logic [LW-1:0]     r_rd, n_rd, r_wr, n_wr;
    logic [NW-1:0]     r_u, n_u, r_v, n_v, r_x, n_x, r_xn, n_xn;
    logic [AW-1:0]     r_i, n_i, r_inext, n_inext, r_arc, n_arc;
    logic [LW-1:0]     r_du, n_du, r_lab, n_lab, r_m, n_m, r_dsrc, n_dsrc;
    logic [CW-1:0]     r_df, n_df;
    logic [imfe_pkg::FLOW_W-1:0] r_flow, n_flow;
    logic [imfe_pkg::CNT_W-1:0]  r_count, n_count;
    logic              r_nz, n_nz;

    // derived values
    logic [AW:0]       fill_plus2;
    logic [LW:0]       dist_q_inc;
    logic [imfe_pkg::FLOW_W:0] flow_sum;
    logic              bfs_take;
    logic              adm;
    logic [LW-1:0]     m_inc;

    assign fill_plus2 = {1'b0, r_fill} + {{AW{1'b0}}, 1'b1} + {{AW{1'b0}}, 1'b1};
    assign dist_q_inc = {1'b0, di_q} + {{LW{1'b0}}, 1'b1};
    assign flow_sum   = {1'b0, r_flow} + {{(imfe_pkg::FLOW_W - CW + 1){1'b0}}, r_df};
    assign bfs_take   = !se_q && !(ex_q && (r_v != r_a) && (r_v != r_b));
    assign adm        = r_nz && ({1'b0, r_du} == dist_q_inc);
    assign m_inc      = r_m + {{(LW-1){1'b0}}, 1'b1};

    // operation decode: memory ports and next register values
    always_comb begin
        tg_we = 1'b0; rs_we = 1'b0; lk_we = 1'b0; hd_we = 1'b0;
        cu_we = 1'b0; pa_we = 1'b0; di_we = 1'b0; hi_we = 1'b0;
        se_we = 1'b0; ff_we = 1'b0; ex_we = 1'b0; op_we = 1'b0;
        tg_wa = r_i; rs_wa = r_arc; lk_wa = r_i;
        hd_wa = r_a; cu_wa = r_u; pa_wa = r_v; di_wa = r_v; se_wa = r_v;
        ff_wa = r_wr[NW-1:0]; ex_wa = r_a; op_wa = r_x; hi_wa = r_du;
        tg_ra = r_i; rs_ra = r_i; lk_ra = r_i;
        hd_ra = r_u; cu_ra = r_u; pa_ra = r_x; di_ra = r_u; se_ra = r_v;
        ff_ra = r_rd[NW-1:0]; ex_ra = r_v; op_ra = r_x; hi_ra = r_du;
        tg_wd = r_b; ff_wd = r_v; rs_wd = r_cap;
        lk_wd = hd_q; hd_wd = r_i; cu_wd = r_i; pa_wd = r_i;
        di_wd = r_du; hi_wd = hi_q;
        se_wd = 1'b1; ex_wd = 1'b1; op_wd = 1'b1;

        n_cmd = r_cmd; n_a = r_a; n_b = r_b; n_cap = r_cap;
        n_fill = r_fill; n_drop = r_drop; n_n = r_n;
        n_rd = r_rd; n_wr = r_wr; n_u = r_u; n_v = r_v; n_x = r_x; n_xn = r_xn;
        n_i = r_i; n_inext = r_inext; n_arc = r_arc;
        n_du = r_du; n_lab = r_lab; n_m = r_m; n_dsrc = r_dsrc;
        n_df = r_df; n_flow = r_flow; n_count = r_count; n_nz = r_nz;

        case (i_ctl.op)
            // clearing pass after reset
            imfe_pkg::ST_CLR0: begin
                hd_we = 1'b1; hd_wa = r_n[NW-1:0]; hd_wd = '0;
                ex_we = 1'b1; ex_wa = r_n[NW-1:0]; ex_wd = 1'b0;
                n_n = (r_n == imfe_pkg::LABEL_TOP) ? '0 : r_n + 11'd1;
            end
            imfe_pkg::ST_IDLE: begin
                n_cmd = i_command; n_a = i_node_a; n_b = i_node_b; n_cap = i_capacity;
            end
            imfe_pkg::ST_DISP: begin
                if (r_cmd == imfe_pkg::CMD_LOAD && fill_plus2 > imfe_pkg::ARC_LAST)
                    n_drop = 1'b1;
                n_flow = '0;
                n_count = '0;
            end
            // edge load: forward arc then reverse arc
            imfe_pkg::ST_LD1: hd_ra = r_a;
            imfe_pkg::ST_LD2: begin
                tg_we = 1'b1; tg_wa = r_fill + 14'd1; tg_wd = r_b;
                rs_we = 1'b1; rs_wa = r_fill + 14'd1; rs_wd = r_cap;
                lk_we = 1'b1; lk_wa = r_fill + 14'd1; lk_wd = hd_q;
                hd_we = 1'b1; hd_wa = r_a; hd_wd = r_fill + 14'd1;
            end
            imfe_pkg::ST_LD3: hd_ra = r_b;
            imfe_pkg::ST_LD4: begin
                tg_we = 1'b1; tg_wa = fill_plus2[AW-1:0]; tg_wd = r_a;
                rs_we = 1'b1; rs_wa = fill_plus2[AW-1:0]; rs_wd = '0;
                lk_we = 1'b1; lk_wa = fill_plus2[AW-1:0]; lk_wd = hd_q;
                hd_we = 1'b1; hd_wa = r_b; hd_wd = fill_plus2[AW-1:0];
                n_fill = fill_plus2[AW-1:0];
            end
            imfe_pkg::ST_EXCL: begin
                ex_we = 1'b1; ex_wa = r_a; ex_wd = 1'b1;
            end
            // per-run clear of labels, marks and histogram
            imfe_pkg::ST_RCLR: begin
                hi_we = 1'b1; hi_wa = r_n; hi_wd = '0;
                if (r_n != imfe_pkg::LABEL_INF) begin
                    se_we = 1'b1; se_wa = r_n[NW-1:0]; se_wd = 1'b0;
                    op_we = 1'b1; op_wa = r_n[NW-1:0]; op_wd = 1'b0;
                    di_we = 1'b1; di_wa = r_n[NW-1:0]; di_wd = imfe_pkg::LABEL_INF;
                end
                n_n = (r_n == imfe_pkg::LABEL_INF) ? '0 : r_n + 11'd1;
            end
            // breadth-first labeling from the sink
            imfe_pkg::ST_BINIT: begin
                se_we = 1'b1; se_wa = r_b; se_wd = 1'b1;
                di_we = 1'b1; di_wa = r_b; di_wd = '0;
                ff_we = 1'b1; ff_wa = '0; ff_wd = r_b;
                n_rd = '0;
                n_wr = 11'd1;
            end
            imfe_pkg::ST_BPOP: begin
                ff_ra = r_rd[NW-1:0];
                if (r_rd != r_wr)
                    n_rd = r_rd + 11'd1;
            end
            imfe_pkg::ST_BU: begin
                n_u = ff_q; hd_ra = ff_q; di_ra = ff_q;
            end
            imfe_pkg::ST_BARC: begin
                n_i = hd_q; n_du = di_q;
            end
            imfe_pkg::ST_BLOOP: begin
                tg_ra = r_i; lk_ra = r_i;
            end
            imfe_pkg::ST_BW: begin
                n_v = tg_q; n_i = lk_q; se_ra = tg_q; ex_ra = tg_q;
            end
            imfe_pkg::ST_BCHK: begin
                if (bfs_take) begin
                    se_we = 1'b1; se_wa = r_v; se_wd = 1'b1;
                    di_we = 1'b1; di_wa = r_v; di_wd = r_du + 11'd1;
                    if (r_wr != imfe_pkg::LABEL_INF) begin
                        ff_we = 1'b1; ff_wa = r_wr[NW-1:0]; ff_wd = r_v;
                        n_wr = r_wr + 11'd1;
                    end
                end
            end
            // label histogram and current arcs
            imfe_pkg::ST_H1: begin
                di_ra = r_n[NW-1:0]; hd_ra = r_n[NW-1:0];
            end
            imfe_pkg::ST_H2: begin
                n_lab = di_q;
                cu_we = 1'b1; cu_wa = r_n[NW-1:0]; cu_wd = hd_q;
                hi_ra = di_q;
                if (r_n[NW-1:0] == r_a)
                    n_dsrc = di_q;
            end
            imfe_pkg::ST_H3: begin
                hi_we = 1'b1; hi_wa = r_lab; hi_wd = hi_q + 11'd1;
                if (r_n == imfe_pkg::LABEL_TOP) begin
                    n_n = '0;
                    n_u = r_a;
                end else begin
                    n_n = r_n + 11'd1;
                end
            end
            // augment: find the bottleneck
            imfe_pkg::ST_P0: begin
                n_x = r_b; n_df = '1;
            end
            imfe_pkg::ST_P1: pa_ra = r_x;
            imfe_pkg::ST_P2: begin
                n_arc = pa_q; rs_ra = pa_q; tg_ra = pa_q ^ 14'd1;
            end
            imfe_pkg::ST_P3: begin
                if (rs_q < r_df)
                    n_df = rs_q;
                n_x = tg_q;
            end
            // augment: push the bottleneck along the path
            imfe_pkg::ST_P4: n_x = r_b;
            imfe_pkg::ST_P5: begin
                pa_ra = r_x; op_ra = r_x;
                if (r_x == r_a) begin
                    n_flow = flow_sum[imfe_pkg::FLOW_W] ? '1
                                                         : flow_sum[imfe_pkg::FLOW_W-1:0];
                    n_u = r_a;
                end
            end
            imfe_pkg::ST_P6: begin
                n_arc = pa_q;
                if (!op_q)
                    n_count = r_count + 11'd1;
                op_we = 1'b1; op_wa = r_x; op_wd = 1'b1;
                rs_ra = pa_q; tg_ra = pa_q ^ 14'd1;
            end
            imfe_pkg::ST_P7: begin
                rs_we = 1'b1; rs_wa = r_arc; rs_wd = rs_q - r_df;
                rs_ra = r_arc ^ 14'd1;
                n_xn = tg_q;
            end
            imfe_pkg::ST_P8: begin
                rs_we = 1'b1; rs_wa = r_arc ^ 14'd1; rs_wd = rs_q + r_df;
                n_x = r_xn;
            end
            // advance
            imfe_pkg::ST_A0: begin
                cu_ra = r_u; di_ra = r_u;
            end
            imfe_pkg::ST_A1: begin
                n_i = cu_q; n_du = di_q;
            end
            imfe_pkg::ST_A2: begin
                tg_ra = r_i; rs_ra = r_i; lk_ra = r_i;
            end
            imfe_pkg::ST_A3: begin
                n_v = tg_q; n_nz = (rs_q != '0); n_inext = lk_q; di_ra = tg_q;
            end
            imfe_pkg::ST_A4: begin
                if (adm) begin
                    pa_we = 1'b1; pa_wa = r_v; pa_wd = r_i;
                    cu_we = 1'b1; cu_wa = r_u; cu_wd = r_i;
                    n_u = r_v;
                end else begin
                    n_i = r_inext;
                end
            end
            // retreat: minimum label over residual arcs
            imfe_pkg::ST_R0: begin
                hd_ra = r_u; n_m = imfe_pkg::LABEL_TOP;
            end
            imfe_pkg::ST_R1: n_i = hd_q;
            imfe_pkg::ST_R2: begin
                tg_ra = r_i; rs_ra = r_i; lk_ra = r_i;
            end
            imfe_pkg::ST_R3: begin
                n_nz = (rs_q != '0); n_inext = lk_q; di_ra = tg_q;
            end
            imfe_pkg::ST_R4: begin
                if (r_nz && di_q < r_m)
                    n_m = di_q;
                n_i = r_inext;
            end
            // gap check and relabel
            imfe_pkg::ST_R5: hi_ra = r_du;
            imfe_pkg::ST_R6: begin
                hi_we = 1'b1; hi_wa = r_du; hi_wd = hi_q - 11'd1;
                if (hi_q != 11'd1) begin
                    di_we = 1'b1; di_wa = r_u; di_wd = m_inc;
                    if (r_u == r_a)
                        n_dsrc = m_inc;
                end
            end
            imfe_pkg::ST_R7: begin
                hi_ra = m_inc; hd_ra = r_u;
            end
            imfe_pkg::ST_R8: begin
                hi_we = 1'b1; hi_wa = m_inc; hi_wd = hi_q + 11'd1;
                cu_we = 1'b1; cu_wa = r_u; cu_wd = hd_q;
                pa_ra = r_u;
            end
            imfe_pkg::ST_R9: tg_ra = pa_q ^ 14'd1;
            imfe_pkg::ST_R10: n_u = tg_q;
            default: begin
            end
        endcase
    end

    // arc stores
    always_ff @(posedge i_clk) begin
        if (tg_we) mem_target[tg_wa] <= tg_wd;
        tg_q <= mem_target[tg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (rs_we) mem_resid[rs_wa] <= rs_wd;
        rs_q <= mem_resid[rs_ra];
    end
    always_ff @(posedge i_clk) begin
        if (lk_we) mem_link[lk_wa] <= lk_wd;
        lk_q <= mem_link[lk_ra];
    end

    // per-node stores and label histogram
    always_ff @(posedge i_clk) begin
        if (hd_we) mem_head[hd_wa] <= hd_wd;
        hd_q <= mem_head[hd_ra];
    end
    always_ff @(posedge i_clk) begin
        if (cu_we) mem_cur[cu_wa] <= cu_wd;
        cu_q <= mem_cur[cu_ra];
    end
    always_ff @(posedge i_clk) begin
        if (pa_we) mem_par[pa_wa] <= pa_wd;
        pa_q <= mem_par[pa_ra];
    end
    always_ff @(posedge i_clk) begin
        if (di_we) mem_dist[di_wa] <= di_wd;
        di_q <= mem_dist[di_ra];
    end
    always_ff @(posedge i_clk) begin
        if (hi_we) mem_hist[hi_wa] <= hi_wd;
        hi_q <= mem_hist[hi_ra];
    end
    always_ff @(posedge i_clk) begin
        if (se_we) mem_seen[se_wa] <= se_wd;
        se_q <= mem_seen[se_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ff_we) mem_fifo[ff_wa] <= ff_wd;
        ff_q <= mem_fifo[ff_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ex_we) mem_excl[ex_wa] <= ex_wd;
        ex_q <= mem_excl[ex_ra];
    end
    always_ff @(posedge i_clk) begin
        if (op_we) mem_onp[op_wa] <= op_wd;
        op_q <= mem_onp[op_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 14'd1;
            r_drop <= 1'b0;
            r_n    <= '0;
            r_rd   <= '0;
            r_wr   <= '0;
        end else begin
            r_fill <= n_fill;
            r_drop <= n_drop;
            r_n    <= n_n;
            r_rd   <= n_rd;
            r_wr   <= n_wr;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_a <= n_a; r_b <= n_b; r_cap <= n_cap;
        r_u <= n_u; r_v <= n_v; r_x <= n_x; r_xn <= n_xn;
        r_i <= n_i; r_inext <= n_inext; r_arc <= n_arc;
        r_du <= n_du; r_lab <= n_lab; r_m <= n_m; r_dsrc <= n_dsrc;
        r_df <= n_df; r_flow <= n_flow; r_count <= n_count; r_nz <= n_nz;
    end

    // status to the controller
    assign o_sts.cmd        = r_cmd;
    assign o_sts.full       = fill_plus2 > imfe_pkg::ARC_LAST;
    assign o_sts.same_ab    = (r_a == r_b);
    assign o_sts.n_1023     = (r_n == imfe_pkg::LABEL_TOP);
    assign o_sts.n_1024     = (r_n == imfe_pkg::LABEL_INF);
    assign o_sts.fifo_empty = (r_rd == r_wr);
    assign o_sts.i_zero     = (r_i == '0);
    assign o_sts.bfs_take   = bfs_take;
    assign o_sts.src_done   = (r_dsrc >= imfe_pkg::LABEL_INF);
    assign o_sts.u_is_sink  = (r_u == r_b);
    assign o_sts.u_is_src   = (r_u == r_a);
    assign o_sts.x_is_src   = (r_x == r_a);
    assign o_sts.adm        = adm;
    assign o_sts.hist_one   = (hi_q == 11'd1);

    assign o_max_flow        = r_flow;
    assign o_path_node_count = r_count;
    assign o_status          = r_drop;

endmodule

@@ sv/isap_max_flow_engine.sv @@
// run: a clearing sweep, breadth-first labeling from the sink and a histogram sweep,
// then arc scan steps, augmenting paths and relabels
// throughput: one command at a time; busy stays high until the command completes
// reset: synchronous, active low; a clearing pass then clears adjacency and exclusion
// results are strobed by o_valid for one cycle and the receiver cannot stall
`timescale 1ns / 1ps

module isap_max_flow_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_command,
    input  logic [imfe_pkg::NODE_W-1:0]          i_node_a,
    input  logic [imfe_pkg::NODE_W-1:0]          i_node_b,
    input  logic [imfe_pkg::CAP_W-1:0]           i_capacity,
    output logic                                 o_valid,
    output logic [imfe_pkg::FLOW_W-1:0]          o_max_flow,
    output logic [imfe_pkg::CNT_W-1:0]           o_path_node_count,
    output logic                                 o_status
);

    imfe_pkg::t_ctl ctl;
    imfe_pkg::t_sts sts;

    // sequencer
    imfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // memories and working registers
    imfe_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .i_command         (i_command),
        .i_node_a          (i_node_a),
        .i_node_b          (i_node_b),
        .i_capacity        (i_capacity),
        .o_sts             (sts),
        .o_max_flow        (o_max_flow),
        .o_path_node_count (o_path_node_count),
        .o_status          (o_status)
    );

    assign busy    = (ctl.op != imfe_pkg::ST_IDLE);
    assign o_valid = (ctl.op == imfe_pkg::ST_DONE);

`ifndef NO_ASSERTIONS
    // reset always enters the clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    // a transfer in makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // result strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    // node count never exceeds the node space
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_path_node_count <= 11'd1024))
        else $error("path node count out of range");
`endif

endmodule
